// File: src/lrs_pkg.sv
// Package: shared types and constants for the base-10 LSD radix sorter.
package lrs_pkg;

  localparam int unsigned MaxItems = 64;
  localparam int unsigned Radix    = 10;
  localparam int unsigned ValW     = 31;
  localparam int unsigned EntW     = 2 * ValW;  // stored value and its remaining quotient
  localparam int unsigned AddrW    = $clog2(MaxItems);
  localparam int unsigned CntW     = $clog2(MaxItems + 1);
  localparam int unsigned DigW     = $clog2(Radix);

  typedef struct packed {
    logic [ValW-1:0] value;
    logic            is_final;
  } in_item_t;

  typedef struct packed {
    logic [ValW-1:0] sorted_value;
    logic            end_of_set;
    logic            overflow;
  } out_item_t;

  typedef enum logic [2:0] {
    StLoad,
    StCount,
    StScan,
    StScatter,
    StEmit
  } state_e;

  // Divide by ten through reciprocal multiplication; exact for every 31-bit operand.
  function automatic logic [ValW-1:0] div10(input logic [ValW-1:0] x);
    logic [63:0] p;
    p = {33'd0, x} * {32'd0, 32'hCCCC_CCCD};
    return {3'd0, p[62:35]};
  endfunction

  // Lowest decimal digit of x, given q = x / 10.
  function automatic logic [DigW-1:0] mod10(input logic [ValW-1:0] x,
                                            input logic [ValW-1:0] q);
    logic [ValW-1:0] r;
    r = x - ((q << 3) + (q << 1));
    return r[DigW-1:0];
  endfunction

endpackage

// File: src/lsd_radix_sort_base10.sv
// Top level: buffered base-10 LSD radix sorter.
//
//  channel | direction | payload     | transaction
//  in      | input     | in_item_t   | one value, is_final starts the sort
//  out     | output    | out_item_t  | one sorted value, end_of_set on last
//
// Load accepts one value per cycle. Per decimal place the sort counts digits
// from memory A, forms the prefix sum over the digit counters, then scatters
// from last to first into memory B; the two memories then swap role.
// Each entry carries the value and its quotient by the current place weight, so
// the digit is the quotient modulo ten; at most ten places are visited.
// Emit waits for each read to land in a one-entry output register before the next.
// Reset clears control state only; the memories are not cleared. A stall on the
// output holds the read pipeline; the input is ready only while loading.
module lsd_radix_sort_base10 (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lrs_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lrs_pkg::out_item_t  out_data_o
);
  import lrs_pkg::*;

  state_e state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [ValW-1:0]   max_q, max_d;       // running max, then max / weight while sorting
  logic              ovf_q, ovf_d;
  logic              sel_q, sel_d;       // which memory holds the current data
  logic [CntW-1:0]   idx_q, idx_d;       // read index
  logic              rv_q, rv_d;         // a read is in flight
  logic [CntW-1:0]   ridx_q, ridx_d;     // index of the in-flight read
  logic [CntW-1:0]   cnt_q [Radix];
  logic [CntW-1:0]   cnt_d [Radix];
  logic [DigW-1:0]   scan_q, scan_d;
  logic              ov_q, ov_d;
  out_item_t         out_q, out_d;

  // Memory ports.
  logic              we0, we1;
  logic [AddrW-1:0]  wa, ra;
  logic [EntW-1:0]   wd, rd0, rd1, rd;

  lrs_ram #(.Width(EntW), .Depth(MaxItems)) u_ram0 (
    .clk_i, .we_i(we0), .waddr_i(wa), .wdata_i(wd), .raddr_i(ra), .rdata_o(rd0));
  lrs_ram #(.Width(EntW), .Depth(MaxItems)) u_ram1 (
    .clk_i, .we_i(we1), .waddr_i(wa), .wdata_i(wd), .raddr_i(ra), .rdata_o(rd1));

  assign rd = sel_q ? rd1 : rd0;

  logic [ValW-1:0] rd_val;
  logic [ValW-1:0] rd_quo;
  logic [ValW-1:0] quo10;
  logic [DigW-1:0] dig;
  logic            we;
  logic            wsel;
  logic            more;
  logic [CntW-1:0] pos;

  assign rd_val = rd[EntW-1:ValW];
  assign rd_quo = rd[ValW-1:0];
  assign quo10  = div10(rd_quo);
  assign dig    = mod10(rd_quo, quo10);
  // Another place is due while max / weight is ten or more.
  assign more = (max_q >= ValW'(Radix));
  assign pos = cnt_q[dig] - 1'b1;
  assign we0 = we & !wsel;
  assign we1 = we & wsel;

  assign in_ready_o  = (state_q == StLoad);
  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    max_d   = max_q;
    ovf_d   = ovf_q;
    sel_d   = sel_q;
    idx_d   = idx_q;
    rv_d    = 1'b0;
    ridx_d  = ridx_q;
    cnt_d   = cnt_q;
    scan_d  = scan_q;
    ov_d    = ov_q;
    out_d   = out_q;
    we      = 1'b0;
    wsel    = sel_q;
    wa      = '0;
    wd      = {in_data_i.value, in_data_i.value};
    ra      = idx_q[AddrW-1:0];

    // drop the output word once taken, in any state
    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end

    case (state_q)
      StLoad: begin
        if (in_valid_i) begin
          if (count_q < CntW'(MaxItems)) begin
            we      = 1'b1;
            wa      = count_q[AddrW-1:0];
            count_d = count_q + 1'b1;
            if (in_data_i.value > max_q) begin
              max_d = in_data_i.value;
            end
          end else begin
            ovf_d = 1'b1;
          end
          if (in_data_i.is_final) begin
            idx_d   = '0;
            for (int k = 0; k < Radix; k++) cnt_d[k] = '0;
            // max of zero skips every pass
            if ((in_data_i.value > max_q && count_q < CntW'(MaxItems)) || max_q != '0) begin
              state_d = StCount;
            end else begin
              state_d = StEmit;
            end
          end
        end
      end
      StCount: begin
        // issue reads ascending, count digits as data returns
        if (idx_q < count_q) begin
          rv_d   = 1'b1;
          idx_d  = idx_q + 1'b1;
        end
        if (rv_q) begin
          cnt_d[dig] = cnt_q[dig] + 1'b1;
        end
        if (!rv_q && idx_q >= count_q) begin
          scan_d  = DigW'(1);
          state_d = StScan;
        end
      end
      StScan: begin
        cnt_d[scan_q] = cnt_q[scan_q] + cnt_q[scan_q - 1'b1];
        scan_d = scan_q + 1'b1;
        if (scan_q == DigW'(Radix - 1)) begin
          idx_d   = count_q;
          state_d = StScatter;
        end
      end
      StScatter: begin
        // read descending, place stably into the other memory
        ra = AddrW'(idx_q - 1'b1);
        if (idx_q != '0) begin
          rv_d  = 1'b1;
          idx_d = idx_q - 1'b1;
        end
        if (rv_q) begin
          we         = 1'b1;
          wsel       = !sel_q;
          wa         = pos[AddrW-1:0];
          wd         = {rd_val, quo10};
          cnt_d[dig] = pos;
        end
        if (!rv_q && idx_q == '0) begin
          sel_d = !sel_q;
          idx_d = '0;
          max_d = div10(max_q);
          for (int k = 0; k < Radix; k++) cnt_d[k] = '0;
          if (more) begin
            state_d = StCount;
          end else begin
            state_d = StEmit;
          end
        end
      end
      StEmit: begin
        // land returned data into the free output register
        if (rv_q) begin
          if (!ov_d) begin
            out_d.sorted_value = rd_val;
            out_d.end_of_set   = (ridx_q + 1'b1 == count_q);
            out_d.overflow     = ovf_q;
            ov_d = 1'b1;
            if (ridx_q + 1'b1 == count_q) begin
              count_d = '0;
              max_d   = '0;
              ovf_d   = 1'b0;
              state_d = StLoad;
            end
          end else begin
            // hold the read until the register frees
            rv_d = 1'b1;
            ra   = ridx_q[AddrW-1:0];
          end
        end else if (idx_q < count_q && !(ov_q && !out_ready_i)) begin
          rv_d   = 1'b1;
          ridx_d = idx_q;
          idx_d  = idx_q + 1'b1;
        end
      end
      default: state_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      count_q <= '0;
      max_q   <= '0;
      ovf_q   <= 1'b0;
      sel_q   <= 1'b0;
      idx_q   <= '0;
      rv_q    <= 1'b0;
      ridx_q  <= '0;
      scan_q  <= '0;
      ov_q    <= 1'b0;
      for (int k = 0; k < Radix; k++) cnt_q[k] <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      max_q   <= max_d;
      ovf_q   <= ovf_d;
      sel_q   <= sel_d;
      idx_q   <= idx_d;
      rv_q    <= rv_d;
      ridx_q  <= ridx_d;
      scan_q  <= scan_d;
      ov_q    <= ov_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end
endmodule

// File: src/lrs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module lrs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: verif/lsd_radix_sort_base10_test.sv
// Testbench for the base-10 LSD radix sorter: directed and random sets checked against a predictor.
module lsd_radix_sort_base10_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lrs_pkg::*;

  localparam int unsigned Capacity   = MaxItems;
  localparam int unsigned StallLimit = 200000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;

  lsd_radix_sort_base10 u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  // Predictor state: the values of the set being loaded.
  logic [ValW-1:0] set_vals[$];
  logic            set_overflow = 1'b0;
  out_item_t       sorted_queue[$];

  int unsigned mismatches = 0;
  int unsigned idle_pct   = 27;   // shared idling rate of both sides
  bit          hold_off   = 1'b0; // receiver holds off while set
  int unsigned quiet      = 0;

  // Stable ascending order; same result as the radix sort would give.
  task automatic predict_sorted();
    logic [ValW-1:0] vals[$];
    logic [ValW-1:0] t;
    out_item_t       o;
    vals = set_vals;
    for (int i = 1; i < vals.size(); i++) begin
      t = vals[i];
      for (int j = i - 1; j >= 0 && vals[j] > t; j--) begin
        vals[j+1] = vals[j];
        vals[j] = t;
      end
    end
    foreach (vals[i]) begin
      o.sorted_value = vals[i];
      o.end_of_set   = (i == vals.size() - 1);
      o.overflow     = set_overflow;
      sorted_queue   = {sorted_queue, o};
    end
    set_vals.delete();
    set_overflow = 1'b0;
  endtask

  // Offer one transaction and hold it until accepted; update the predictor.
  // Valid stays high after acceptance until the next offer or an idle cycle drops it.
  task automatic send_value(input logic [ValW-1:0] v, input bit fin);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{value: v, is_final: fin};
    do @(posedge clk_i); while (!in_ready_o);
    if (set_vals.size() < Capacity) set_vals = {set_vals, v};
    else set_overflow = 1'b1;
    if (fin) predict_sorted();
  endtask

  // Receiver: drop ready at random, hold off entirely when asked.
  always @(posedge clk_i) begin
    out_ready_i <= !hold_off && ($urandom_range(99) >= idle_pct);
  end

  // Check each accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    out_item_t exp_item;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (sorted_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data_o);
      end else begin
        exp_item = sorted_queue.pop_front();
        if (out_data_o !== exp_item) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", exp_item, out_data_o);
        end
      end
    end
  end

  // Watchdog: count cycles with no transaction on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= StallLimit) begin
      $display("lsd_radix_sort_base10_test NOT OK");
      $finish;
    end
  end

  function automatic logic [ValW-1:0] rand_value();
    case ($urandom_range(3))
      0: rand_value = ValW'($urandom_range(9));
      1: rand_value = ValW'($urandom_range(99999));
      2: rand_value = ValW'($urandom) | 31'h4000_0000;
      default: rand_value = ValW'($urandom);
    endcase
  endfunction

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sorted_queue.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic test_extremes();
    send_value('0, 1'b1);
    send_value(31'h7FFF_FFFF, 1'b1);
    send_value(31'h7FFF_FFFF, 1'b0);
    send_value('0, 1'b0);
    send_value(31'd1_000_000_000, 1'b0);
    send_value(31'd999_999_999, 1'b0);
    send_value(31'h5555_5555, 1'b0);
    send_value(31'h2AAA_AAAA, 1'b1);
    send_value(31'd7, 1'b0);
    send_value(31'd7, 1'b0);
    send_value(31'd3, 1'b1);
  endtask

  // Fill the buffer exactly, then overflow with the final item.
  task automatic test_full_buffer();
    for (int i = 0; i < Capacity; i++) send_value(ValW'($urandom_range(999)), 1'b0);
    send_value(31'd12345, 1'b1);
  endtask

  task automatic test_random_sets();
    int n;
    for (int s = 0; s < 2; s++) begin
      n = int'($urandom_range(8)) + 1;
      for (int i = 0; i < n; i++) send_value(rand_value(), i == n - 1);
    end
  endtask

  // Hold the receiver off while sets keep arriving, so the input stalls.
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int s = 0; s < 2; s++)
        for (int i = 0; i < 5; i++) send_value(rand_value(), i == 4);
    join
  endtask

  task automatic test_no_idle();
    idle_pct = 0;
    for (int i = 0; i < 20; i++) send_value(rand_value(), i % 10 == 9);
    idle_pct = 27;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    wait_drained();   // sender pauses until every result is back
    test_full_buffer();
    test_random_sets();
    test_backpressure();
    test_no_idle();
    wait_drained();
    if (mismatches == 0 && sorted_queue.size() == 0) begin
      $display("lsd_radix_sort_base10_test OK");
    end else begin
      $display("lsd_radix_sort_base10_test NOT OK");
    end
    $finish;
  end
endmodule
